@@ rtl/power_key_short_long_press_assert.svh @@
// Assertion macros shared by the power key checker.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef POWER_KEY_SHORT_LONG_PRESS_ASSERT_SVH
`define POWER_KEY_SHORT_LONG_PRESS_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PK_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("power key assertion failed");

// Next-cycle implication, disabled during reset
`define PK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("power key assertion failed");

`endif

@@ rtl/pk_pkg.sv @@
// Package for the power key block: field widths, codes, item and result types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pk_pkg;

  localparam int TIME_W     = 32;
  localparam int CFG_W      = 16;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 24;

  // Program state codes
  localparam logic [1:0] ST_OTHER   = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_READY   = 2'd2;
  localparam logic [1:0] ST_RUNNING = 2'd3;

  // Pending action codes
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;
  localparam logic [1:0] ACT_ERROR = 2'd3;

  // Command codes
  localparam logic CMD_POLL = 1'b0;
  localparam logic CMD_INIT = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CFG_W-1:0] HOLD_RST     = 16'd2000;

  typedef struct packed {
    logic              command;
    logic              key_down;
    logic [TIME_W-1:0] now_ms;
    logic [1:0]        program_state;
    logic              ui_standby;
  } pk_item_t;

  typedef struct packed {
    logic             key_pressed;
    logic [CNT_W-1:0] short_presses;
    logic             start_program;
    logic             stop_program;
    logic             raise_error;
    logic             power_off;
  } pk_result_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] hold_time;
  } pk_cfg_t;

endpackage

@@ rtl/power_key_short_long_press.sv @@
// Power key block: debounced push button with short-press actions and long-hold
// power-off. An accepted poll transaction passes the input register and then the
// result register before its result shows on the out_ side, and a new transaction
// is taken every cycle while the out_ side is not stalled; the rate is set by the
// update step, whose longest path is a 32-bit time subtract and compare feeding
// the state registers. Configuration writes are taken in any cycle on the cfg_
// channel (index 0 debounce time, index 1 hold time, other indexes ignored) and
// are meant for idle periods.
// Depends on pk_pkg, pk_in_stage and pk_core.
`timescale 1ns / 1ps

module power_key_short_long_press (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // key_down[0], now_ms[32:1], program_state[34:33], ui_standby[35], zero pad
  input  logic [pk_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command[0]
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // key_pressed[0], short_presses[16:1], start_program[17], stop_program[18],
  // raise_error[19], power_off[20], zero pad
  output logic [pk_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pk_pkg::CFG_W-1:0]       cfg_data
);
  import pk_pkg::*;

  pk_cfg_t    cfg_r;
  pk_item_t   item;
  pk_result_t result;
  pk_result_t res_r;
  logic       item_valid;
  logic       advance;
  logic       out_valid_r;

  // Move the held item into the result register when that register frees up
  assign advance = item_valid && (!out_valid_r || out_tready);

  pk_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  pk_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (item),
    .cfg    (cfg_r),
    .result (result)
  );

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time <= DEBOUNCE_RST;
      cfg_r.hold_time     <= HOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE: cfg_r.debounce_time <= cfg_data;
        REG_HOLD:     cfg_r.hold_time     <= cfg_data;
        default:      cfg_r               <= cfg_r;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.power_off, res_r.raise_error, res_r.stop_program,
                       res_r.start_program, res_r.short_presses, res_r.key_pressed};

endmodule

@@ rtl/pk_in_stage.sv @@
// Input register of the power key block: unpacks and holds one stream transaction.
// Depends on pk_pkg.
`timescale 1ns / 1ps

module pk_in_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [pk_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                          in_tuser,
  input  logic                          advance,
  output logic                          item_valid,
  output pk_pkg::pk_item_t              item
);
  import pk_pkg::*;

  logic     valid_r;
  pk_item_t item_r;

  // Take a new transaction when empty or when the held one moves on
  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // Unpack fields; payload needs no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.command       <= in_tuser;
      item_r.key_down      <= in_tdata[0];
      item_r.now_ms        <= in_tdata[32:1];
      item_r.program_state <= in_tdata[34:33];
      item_r.ui_standby    <= in_tdata[35];
    end
  end

endmodule

@@ rtl/pk_core.sv @@
// Debounce and press classification state of the power key block.
// Depends on pk_pkg; computes one result per item and updates state on fire.
`timescale 1ns / 1ps

module pk_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  pk_pkg::pk_item_t   item,
  input  pk_pkg::pk_cfg_t    cfg,
  output pk_pkg::pk_result_t result
);
  import pk_pkg::*;

  logic              raw_r, raw_nxt;
  logic              stable_r, stable_nxt;
  logic              armed_r, armed_nxt;
  logic [1:0]        pend_r, pend_nxt;
  logic [TIME_W-1:0] lct_r, lct_nxt;
  logic [TIME_W-1:0] press_r, press_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] since_press;
  logic              chg;
  logic              deb_ok;
  logic              edge_ok;
  logic              new_press;
  logic              held_long;
  logic              start_s, stop_s, err_s, poff_s;

  // Both time differences come from the stored stamps; a fresh stamp means zero
  assign since_change = item.now_ms - lct_r;
  assign since_press  = item.now_ms - press_r;
  assign chg          = item.key_down != raw_r;
  assign deb_ok       = chg ? (cfg.debounce_time == '0)
                            : (since_change >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_time});
  assign edge_ok      = (item.key_down != stable_r) && deb_ok;
  assign new_press    = edge_ok && item.key_down;
  assign held_long    = new_press ? (cfg.hold_time == '0)
                                  : (since_press >= {{(TIME_W-CFG_W){1'b0}}, cfg.hold_time});

  // Next state and action flags for the held item
  always_comb begin
    raw_nxt    = raw_r;
    stable_nxt = stable_r;
    armed_nxt  = armed_r;
    pend_nxt   = pend_r;
    lct_nxt    = lct_r;
    press_nxt  = press_r;
    cnt_nxt    = cnt_r;
    start_s    = 1'b0;
    stop_s     = 1'b0;
    err_s      = 1'b0;
    poff_s     = 1'b0;
    if (item.command == CMD_INIT) begin
      raw_nxt    = item.key_down;
      stable_nxt = item.key_down;
      armed_nxt  = 1'b0;
      pend_nxt   = ACT_NONE;
      lct_nxt    = item.now_ms;
      press_nxt  = item.now_ms;
      cnt_nxt    = '0;
    end else begin
      if (chg) begin
        raw_nxt = item.key_down;
        lct_nxt = item.now_ms;
      end
      if (edge_ok) begin
        stable_nxt = item.key_down;
        if (item.key_down) begin
          // Debounced press: stamp it and pick the action for a later release
          press_nxt = item.now_ms;
          priority if (item.program_state == ST_RUNNING) begin
            pend_nxt = ACT_STOP;
          end else if (item.program_state == ST_READY && item.ui_standby) begin
            pend_nxt = ACT_START;
          end else if (item.program_state == ST_EMPTY) begin
            pend_nxt = ACT_ERROR;
          end else begin
            pend_nxt = ACT_NONE;
          end
        end else begin
          // Debounced release: count a short press when armed and quick enough
          if (armed_r && !held_long) begin
            cnt_nxt = cnt_r + 1'b1;
            priority if (pend_r == ACT_STOP && item.program_state == ST_RUNNING) begin
              stop_s = 1'b1;
            end else if (pend_r == ACT_START && item.program_state == ST_READY) begin
              start_s = 1'b1;
            end else if (pend_r == ACT_ERROR && item.program_state == ST_EMPTY) begin
              err_s = 1'b1;
            end else begin
              start_s = 1'b0;
            end
          end
          armed_nxt = 1'b1;
          pend_nxt  = ACT_NONE;
        end
      end
      // Arm once a stable release has been seen
      if (!stable_nxt && !armed_nxt && deb_ok) begin
        armed_nxt = 1'b1;
      end
      // Long hold of an armed press: stop and power off on every poll
      if (stable_nxt && armed_nxt && held_long) begin
        pend_nxt = ACT_NONE;
        stop_s   = 1'b1;
        poff_s   = 1'b1;
      end
    end
  end

  assign result.key_pressed   = stable_nxt;
  assign result.short_presses = cnt_nxt;
  assign result.start_program = start_s;
  assign result.stop_program  = stop_s;
  assign result.raise_error   = err_s;
  assign result.power_off     = poff_s;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 1'b0;
      stable_r <= 1'b0;
      armed_r  <= 1'b0;
      pend_r   <= ACT_NONE;
      lct_r    <= '0;
      press_r  <= '0;
      cnt_r    <= '0;
    end else if (fire) begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      armed_r  <= armed_nxt;
      pend_r   <= pend_nxt;
      lct_r    <= lct_nxt;
      press_r  <= press_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ rtl/pk_checker.sv @@
// Port-level checker for the power key block, bound to the top level.
// Depends on pk_pkg and power_key_short_long_press_assert.svh.
`timescale 1ns / 1ps

`include "power_key_short_long_press_assert.svh"

module pk_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pk_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pk_pkg::*;

  logic key_q, start_q, stop_q, err_q, poff_q;

  assign key_q   = out_tdata[0];
  assign start_q = out_tdata[17];
  assign stop_q  = out_tdata[18];
  assign err_q   = out_tdata[19];
  assign poff_q  = out_tdata[20];

  // Power-off always comes with a stop request
  `PK_ASSERT_IMPL(a_poff_stop, out_tvalid && poff_q, stop_q)
  // Power-off only while the debounced key is down
  `PK_ASSERT_IMPL(a_poff_key, out_tvalid && poff_q, key_q)
  // A short-press start comes on a release
  `PK_ASSERT_IMPL(a_start_release, out_tvalid && start_q, !key_q && !poff_q)
  // At most one short-press action per result
  `PK_ASSERT_IMPL(a_one_action, out_tvalid, $onehot0({start_q, stop_q, err_q}))
  // A stalled result holds
  `PK_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind power_key_short_long_press pk_checker u_pk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ dv/power_key_short_long_press_test.sv @@
// Self-checking testbench for the power key block: directed polls, then press/release
// sequences with random timing under several debounce and hold settings and idle mixes.
// Depends on pk_pkg and power_key_short_long_press.
`timescale 1ns / 1ps

module power_key_short_long_press_test;
  import pk_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int N_DIRECTED    = 26;
  localparam int MAX_REPORTED  = 40;
  // Indexes the block has no register for
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam pk_result_t REP_RELEASED = '{1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam pk_result_t REP_HELD     = '{1'b1, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0};

  typedef struct {
    pk_item_t   item;
    bit         typed;
    pk_result_t want;
  } poll_row_t;

  typedef struct {
    int debounce;
    int hold;
    int idle_pct;
    int stall_pct;
  } phase_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  // Predictor state and register shadow
  logic              key_raw, key_stable, armed;
  logic [1:0]        pending;
  logic [TIME_W-1:0] t_change, t_press;
  logic [CNT_W-1:0]  press_count;
  logic [CFG_W-1:0]  cfg_debounce, cfg_hold;

  pk_result_t  key_reports_q[$];
  logic [31:0] cur_ms = '0;
  int          items_sent = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  // Directed polls: reset value, init extremes, one short press per action,
  // standby gating, long hold with repeated power-off across the wrap
  poll_row_t directed_rows [N_DIRECTED] = '{
    '{'{CMD_POLL, 1'b0, 32'd0,         ST_OTHER,   1'b0}, 1'b1, REP_RELEASED},
    '{'{CMD_INIT, 1'b1, 32'hFFFF_FFF0, ST_READY,   1'b1}, 1'b1, REP_HELD},
    '{'{CMD_INIT, 1'b0, 32'd100,       ST_RUNNING, 1'b1}, 1'b1, REP_RELEASED},
    '{'{CMD_POLL, 1'b0, 32'd130,       ST_READY,   1'b1}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b1, 32'd140,       ST_READY,   1'b1}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b1, 32'd160,       ST_READY,   1'b1}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b0, 32'd200,       ST_READY,   1'b1}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b0, 32'd220,       ST_READY,   1'b1}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b1, 32'd300,       ST_RUNNING, 1'b0}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b1, 32'd320,       ST_RUNNING, 1'b0}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b0, 32'd400,       ST_RUNNING, 1'b0}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b0, 32'd420,       ST_RUNNING, 1'b0}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b1, 32'd500,       ST_EMPTY,   1'b0}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b1, 32'd520,       ST_EMPTY,   1'b0}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b0, 32'd600,       ST_EMPTY,   1'b1}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b0, 32'd620,       ST_EMPTY,   1'b1}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b1, 32'd700,       ST_READY,   1'b1}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b1, 32'd720,       ST_READY,   1'b0}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b0, 32'd800,       ST_RUNNING, 1'b1}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b0, 32'd820,       ST_RUNNING, 1'b1}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b1, 32'd900,       ST_RUNNING, 1'b1}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b1, 32'd920,       ST_RUNNING, 1'b1}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b1, 32'd2920,      ST_RUNNING, 1'b1}, 1'b0, REP_RELEASED},
    '{'{CMD_POLL, 1'b1, 32'hFFFF_FFFF, ST_RUNNING, 1'b1}, 1'b0, REP_RELEASED},
    '{'{CMD_INIT, 1'b1, 32'hFFFF_FFFF, ST_RUNNING, 1'b1}, 1'b1, REP_HELD},
    '{'{CMD_POLL, 1'b1, 32'hFFFF_FFFF, ST_RUNNING, 1'b1}, 1'b0, REP_RELEASED}
  };

  // Register settings per phase, extremes included; zero hold is outside the
  // documented range but still reachable through the port
  phase_t phases [6] = '{
    '{20,    2000,  0,  0},
    '{0,     1,     66, 0},
    '{65535, 65535, 0,  66},
    '{5,     0,     11, 11},
    '{1,     40,    0,  0},
    '{30,    500,   66, 66}
  };

  power_key_short_long_press dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Work out the report for one accepted transaction and advance the key state
  task automatic key_report(input pk_item_t it, output pk_result_t res);
    logic settled;
    res = '0;
    if (it.command == CMD_INIT) begin
      key_raw     = it.key_down;
      key_stable  = it.key_down;
      armed       = 1'b0;
      pending     = ACT_NONE;
      t_change    = it.now_ms;
      t_press     = it.now_ms;
      press_count = '0;
    end else begin
      if (it.key_down != key_raw) begin
        key_raw  = it.key_down;
        t_change = it.now_ms;
      end
      settled = (it.now_ms - t_change) >= {16'd0, cfg_debounce};
      if (it.key_down != key_stable && settled) begin
        key_stable = it.key_down;
        if (it.key_down) begin
          t_press = it.now_ms;
          if (it.program_state == ST_RUNNING)
            pending = ACT_STOP;
          else if (it.program_state == ST_READY && it.ui_standby)
            pending = ACT_START;
          else if (it.program_state == ST_EMPTY)
            pending = ACT_ERROR;
          else
            pending = ACT_NONE;
        end else begin
          // Release inside the hold window counts as a short press
          if (armed && (it.now_ms - t_press) < {16'd0, cfg_hold}) begin
            press_count = press_count + 1'b1;
            if (pending == ACT_STOP && it.program_state == ST_RUNNING)
              res.stop_program = 1'b1;
            else if (pending == ACT_START && it.program_state == ST_READY)
              res.start_program = 1'b1;
            else if (pending == ACT_ERROR && it.program_state == ST_EMPTY)
              res.raise_error = 1'b1;
          end
          armed   = 1'b1;
          pending = ACT_NONE;
        end
      end
      if (!key_stable && !armed && settled)
        armed = 1'b1;
      // Armed press held past the hold time: stop and power off every poll
      if (key_stable && armed && (it.now_ms - t_press) >= {16'd0, cfg_hold}) begin
        pending          = ACT_NONE;
        res.stop_program = 1'b1;
        res.power_off    = 1'b1;
      end
    end
    res.key_pressed   = key_stable;
    res.short_presses = press_count;
  endtask

  // Present one transaction, hold it until taken, then queue its report
  task automatic drive_item(input pk_item_t it, input bit use_typed, input pk_result_t typed);
    pk_result_t res;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.command;
    in_tdata  <= {4'b0, it.ui_standby, it.program_state, it.now_ms, it.key_down};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    key_report(it, res);
    key_reports_q.push_back(use_typed ? typed : res);
    cur_ms     = it.now_ms;
    items_sent = items_sent + 1;
  endtask

  task automatic send_item(input logic cmd, input logic key, input logic [31:0] now,
                           input logic [1:0] pst, input logic stby);
    pk_item_t it;
    it.command       = cmd;
    it.key_down      = key;
    it.now_ms        = now;
    it.program_state = pst;
    it.ui_standby    = stby;
    drive_item(it, 1'b0, REP_RELEASED);
  endtask

  // Stop sending and wait for every queued report, plus the pipeline depth
  task automatic drain_reports();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (key_reports_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DEBOUNCE: cfg_debounce = value;
      REG_HOLD:     cfg_hold = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // One press and release with contact bounce, polls around the debounce edge
  // and a hold that is short, long or right at the hold boundary
  task automatic press_cycle();
    logic [1:0]  pst, pst_rel;
    logic        stby;
    logic [31:0] t_edge, t_acc;
    int          deb, hold, mode, nb, off, dur, polls;
    deb     = int'(cfg_debounce);
    hold    = int'(cfg_hold);
    pst     = 2'($urandom_range(0, 3));
    stby    = 1'($urandom_range(0, 1));
    pst_rel = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : pst;
    mode    = $urandom_range(0, 99);
    nb      = (mode >= 75) ? 0 : $urandom_range(0, 3);
    for (int i = 0; i < nb; i++)
      send_item(CMD_POLL, ~i[0], cur_ms + $urandom_range(0, deb / 2), pst, stby);
    send_item(CMD_POLL, 1'b1, cur_ms + $urandom_range(0, 3), pst, stby);
    t_edge = cur_ms;
    off    = $urandom_range(0, 4) - 1;
    send_item(CMD_POLL, 1'b1, t_edge + deb + off, pst, stby);
    if (off < 0)
      send_item(CMD_POLL, 1'b1, t_edge + deb + $urandom_range(0, 2), pst, stby);
    t_acc = cur_ms;
    if (mode < 45)
      dur = $urandom_range(0, hold);
    else if (mode < 75)
      dur = hold + $urandom_range(0, hold / 2 + 5);
    else
      dur = hold + $urandom_range(0, 2) - 1;
    dur = (dur > deb) ? dur - deb : $urandom_range(0, 3);
    polls = $urandom_range(0, 3);
    for (int i = 1; i <= polls; i++)
      send_item(CMD_POLL, 1'b1, t_acc + dur * i / (polls + 1), pst, stby);
    // release, with bounce on the way out
    nb = (mode >= 75) ? 0 : $urandom_range(0, 2);
    for (int i = 0; i < nb; i++)
      send_item(CMD_POLL, i[0], cur_ms + $urandom_range(0, deb / 2 + 1), pst_rel, stby);
    send_item(CMD_POLL, 1'b0, (nb == 0) ? t_acc + dur : cur_ms + $urandom_range(0, 2),
              pst_rel, stby);
    t_edge = cur_ms;
    off    = $urandom_range(0, 4) - 1;
    send_item(CMD_POLL, 1'b0, t_edge + deb + off, pst_rel, stby);
    if (off < 0)
      send_item(CMD_POLL, 1'b0, t_edge + deb + $urandom_range(0, 2), pst_rel, stby);
    polls = $urandom_range(0, 2);
    for (int i = 0; i < polls; i++)
      send_item(CMD_POLL, 1'b0, cur_ms + $urandom_range(0, deb + 5), pst_rel, stby);
  endtask

  // Mostly press sequences, some stray polls and re-initializations
  task automatic run_random(input int count);
    int target, pick;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)
        send_item(CMD_INIT, 1'($urandom_range(0, 1)), $urandom, 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)));
      else if (pick < 7)
        send_item(CMD_POLL, 1'($urandom_range(0, 1)), $urandom, 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)));
      else if (pick < 18)
        send_item(CMD_POLL, 1'($urandom_range(0, 1)),
                  cur_ms + $urandom_range(0, cfg_debounce + cfg_hold + 10),
                  2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      else
        press_cycle();
    end
  endtask

  task automatic check_field(input string label, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches = mismatches + 1;
      if (mismatches <= MAX_REPORTED)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
    end
  endtask

  // Report checker
  always @(posedge clk) begin
    pk_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.key_pressed   = out_tdata[0];
      got.short_presses = out_tdata[16:1];
      got.start_program = out_tdata[17];
      got.stop_program  = out_tdata[18];
      got.raise_error   = out_tdata[19];
      got.power_off     = out_tdata[20];
      if (key_reports_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= MAX_REPORTED)
          $display("%0t: unexpected report, expected none, actual %h", $time, out_tdata);
      end else begin
        want = key_reports_q.pop_front();
        check_field("key_pressed", {15'd0, want.key_pressed}, {15'd0, got.key_pressed});
        check_field("short_presses", want.short_presses, got.short_presses);
        check_field("start_program", {15'd0, want.start_program},
                    {15'd0, got.start_program});
        check_field("stop_program", {15'd0, want.stop_program}, {15'd0, got.stop_program});
        check_field("raise_error", {15'd0, want.raise_error}, {15'd0, got.raise_error});
        check_field("power_off", {15'd0, want.power_off}, {15'd0, got.power_off});
      end
    end
  end

  initial begin
    key_raw      = 1'b0;
    key_stable   = 1'b0;
    armed        = 1'b0;
    pending      = ACT_NONE;
    t_change     = '0;
    t_press      = '0;
    press_count  = '0;
    cfg_debounce = DEBOUNCE_RST;
    cfg_hold     = HOLD_RST;

    // Reset
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under the reset register values
    for (int i = 0; i < N_DIRECTED; i++)
      drive_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    // Random phases, each under its own registers and idle mix
    for (int p = 0; p < 6; p++) begin
      drain_reports();
      write_reg(REG_DEBOUNCE, 16'(phases[p].debounce));
      write_reg(REG_HOLD, 16'(phases[p].hold));
      write_reg(p[0] ? REG_SPARE_B : REG_SPARE_A, 16'($urandom));
      idle_pct  = phases[p].idle_pct;
      stall_pct = phases[p].stall_pct;
      run_random(65);
      // Pause the sender until everything outstanding has come back
      if (p == 4)
        drain_reports();
      run_random(65);
    end

    drain_reports();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/pk_pkg.sv
rtl/pk_in_stage.sv
rtl/pk_core.sv
rtl/power_key_short_long_press.sv
rtl/pk_checker.sv
dv/power_key_short_long_press_test.sv
